// ===== rtl/core/mmn_pkg.sv =====
// mmn_pkg: shared types and constants of the min-max normalizer
// no dependencies; imported by every module of the block
`default_nettype none

package mmn_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int PIX_BITS    = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_BITS   = $clog2(PIX_BITS);

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [PIX_BITS-1:0] PIX_MAX = {PIX_BITS{1'b1}};

  typedef enum logic [1:0] {
    K_ZERO,
    K_FULL,
    K_DIV
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [SAMPLE_BITS-1:0] off;
    logic [SAMPLE_BITS-1:0] rng;
    logic                   last;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_rd_t;

endpackage

`default_nettype wire

// ===== rtl/core/mmn_front.sv =====
// mmn_front: accepts samples, tracks running min and max, classifies convert samples
// depends on mmn_pkg; feeds mmn_queue
`default_nettype none

module mmn_front
  import mmn_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_last,
  input  wire logic                          q_full,
  output q_wr_t                              q_wr
);

  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic                          pass_start_r, pass_start_nxt;
  logic                          accept;
  kind_t                         kind;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    priority if ((max_r <= min_r) || (in_sample <= min_r)) begin
      kind = K_ZERO;
    end else if (in_sample >= max_r) begin
      kind = K_FULL;
    end else begin
      kind = K_DIV;
    end
  end

  always_comb begin
    min_nxt        = min_r;
    max_nxt        = max_r;
    pass_start_nxt = pass_start_r;
    if (accept) begin
      if (in_opcode == OP_MEASURE) begin
        if (pass_start_r) begin
          min_nxt = in_sample;
          max_nxt = in_sample;
        end else begin
          if (in_sample > max_r) max_nxt = in_sample;
          if (in_sample < min_r) min_nxt = in_sample;
        end
        pass_start_nxt = in_last;
      end else begin
        pass_start_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    q_wr.push       = accept && (in_opcode == OP_CONVERT);
    q_wr.entry.kind = kind;
    q_wr.entry.off  = in_sample - min_r;
    q_wr.entry.rng  = max_r - min_r;
    q_wr.entry.last = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r        <= '0;
      max_r        <= '0;
      pass_start_r <= 1'b1;
    end else begin
      min_r        <= min_nxt;
      max_r        <= max_nxt;
      pass_start_r <= pass_start_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mmn_queue.sv =====
// mmn_queue: short fifo of classified convert transactions between front and back
// depends on mmn_pkg
`default_nettype none

module mmn_queue
  import mmn_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire q_wr_t q_wr,
  output logic       q_full,
  output q_rd_t      q_rd,
  input  wire logic  q_pop
);

  q_entry_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign q_full     = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.entry = mem_r[rd_ptr_r];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && q_rd.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_wr.push && q_full))
    else $error("queue written while full");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) && !q_wr.push |=> (cnt_r == '0))
    else $error("queue count changed without push");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mmn_back.sv =====
// mmn_back: bit-serial divider forming floor(255*off/range) and the result register
// depends on mmn_pkg; drains mmn_queue
`default_nettype none

module mmn_back
  import mmn_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire q_rd_t               q_rd,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [PIX_BITS-1:0]      out_pixel,
  output logic                     out_last_res
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [STEP_BITS-1:0]    step_r, step_nxt;
  logic [SAMPLE_BITS-1:0]  rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0]  rng_r, rng_nxt;
  logic [PIX_BITS-1:0]     num_r, num_nxt;
  logic [PIX_BITS-1:0]     quo_r, quo_nxt;
  logic                    last_r, last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [PIX_BITS-1:0]     out_pixel_r, out_pixel_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [SAMPLE_BITS+PIX_BITS-1:0] prod;
  logic [SAMPLE_BITS:0]            rem_sh;
  logic [SAMPLE_BITS:0]            rem_sub;
  logic                            ge;
  logic                            out_free;

  assign out_valid    = out_valid_r;
  assign out_pixel    = out_pixel_r;
  assign out_last_res = out_last_r;
  assign out_free     = !out_valid_r || out_ready;

  // times 255 as shift and subtract
  assign prod    = {q_rd.entry.off, {PIX_BITS{1'b0}}} - {{PIX_BITS{1'b0}}, q_rd.entry.off};
  assign rem_sh  = {rem_r, num_r[PIX_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, rng_r};
  assign ge      = (rem_sh >= {1'b0, rng_r});

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    rng_nxt       = rng_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pixel_nxt = out_pixel_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_rd.valid) begin
          q_pop    = 1'b1;
          last_nxt = q_rd.entry.last;
          rng_nxt  = q_rd.entry.rng;
          rem_nxt  = prod[SAMPLE_BITS+PIX_BITS-1:PIX_BITS];
          num_nxt  = prod[PIX_BITS-1:0];
          step_nxt = '0;
          unique case (q_rd.entry.kind)
            K_FULL: begin
              quo_nxt   = PIX_MAX;
              state_nxt = S_DONE;
            end
            K_DIV: begin
              quo_nxt   = '0;
              state_nxt = S_DIV;
            end
            default: begin
              quo_nxt   = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DIV: begin
        rem_nxt  = ge ? rem_sub[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
        num_nxt  = {num_r[PIX_BITS-2:0], 1'b0};
        quo_nxt  = {quo_r[PIX_BITS-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(PIX_BITS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pixel_nxt = quo_r;
          out_last_nxt  = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    rem_r       <= rem_nxt;
    rng_r       <= rng_nxt;
    num_r       <= num_nxt;
    quo_r       <= quo_nxt;
    last_r      <= last_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_last_r  <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (step_r != STEP_BITS'(PIX_BITS - 1)) |=> (state_r == S_DIV))
    else $error("divider left early");
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE) && q_rd.valid)
    else $error("queue popped while busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/minmax_normalize_to_8bit_core.sv =====
// minmax_normalize_to_8bit_core: top level of the min-max normalizer to 8 bits
// depends on mmn_pkg, mmn_front, mmn_queue, mmn_back
//
//   channel | ports                                    | direction
//   in      | in_valid in_ready in_opcode in_sample in_last | sample in
//   out     | out_valid out_ready out_pixel out_last_res | pixel out
//
// measure samples are taken every cycle unless the queue is full and give no transaction out
// a convert sample that needs the divider holds the back end for the pop, one quotient bit
// a cycle for 8 bits and the output load; one that saturates or meets a flat channel
// holds it only for the pop and the output load, then its pixel is valid in the output register
// a 2-entry queue lets the front keep taking samples while the back end divides
// synchronous active-low reset clears min, max, queue and output valid
`default_nettype none

module minmax_normalize_to_8bit_core
  import mmn_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [PIX_BITS-1:0]                out_pixel,
  output logic                               out_last_res
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  mmn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_sample (in_sample),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  mmn_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  mmn_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_rd         (q_rd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel    (out_pixel),
    .out_last_res (out_last_res)
  );

endmodule

`default_nettype wire
